@@ rtl/mlpbp_pkg.sv @@
package mlpbp_pkg;

  // Network shape and number formats.
  localparam int NUM_INPUTS       = 2;
  localparam int NUM_HIDDEN       = 2;
  localparam int WEIGHT_FRAC_BITS = 12;
  localparam int SIGMOID_DEPTH    = 256;

  localparam int W_W      = 18;                               // weights and steps
  localparam int NIH      = (NUM_INPUTS + 1) * NUM_HIDDEN;    // input-hidden weights
  localparam int NHO      = NUM_HIDDEN + 1;                   // hidden-output weights
  localparam int ACT_W    = 12;                               // Q0.12 activations
  localparam int SIG_IDX_W = $clog2(SIGMOID_DEPTH);
  localparam int FAN_MAX  = (NUM_INPUTS > NUM_HIDDEN) ? NUM_INPUTS : NUM_HIDDEN;
  localparam int SUM_W    = W_W + $clog2(FAN_MAX + 1);

  // Datapath widths of the back-propagation terms.
  localparam int E_W      = 14;                               // target minus output
  localparam int DO_W     = 24;                               // output delta
  localparam int SDW_W    = 41 - WEIGHT_FRAC_BITS;            // weight times output delta
  localparam int DH_W     = 39 - WEIGHT_FRAC_BITS;            // hidden delta
  localparam int G_W      = (DH_W > DO_W) ? DH_W : DO_W;      // eta times delta
  localparam int MUL_A_W  = (SDW_W > G_W) ? SDW_W : G_W;
  localparam int MUL_B_W  = 24;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  localparam int PE_W     = 16;
  localparam int EACC_W   = 20;
  localparam int CFG_W    = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEARN_RATE     = 2'd0;
  localparam logic [1:0] REG_MOMENTUM       = 2'd1;
  localparam logic [1:0] REG_STOP_THRESHOLD = 2'd2;

  localparam logic [11:0] LEARN_RATE_RST = 12'd2048;
  localparam logic [11:0] MOMENTUM_RST   = 12'd3686;
  localparam logic [15:0] STOP_THR_RST   = 16'd26;

  localparam logic signed [PROD_W-1:0] W_MAX_P = PROD_W'(2 ** (W_W - 1) - 1);
  localparam logic signed [PROD_W-1:0] W_MIN_P = -W_MAX_P - PROD_W'(1);

  localparam logic signed [SUM_W+1:0] SIG_LIM = (SUM_W + 2)'(8 << WEIGHT_FRAC_BITS);

  typedef logic [ACT_W-1:0] sig_table_t [SIGMOID_DEPTH];

  // Sigmoid over -8..8: e^-|x| as powers of e^-1/256 in Q0.32, then 2^44/(2^32+t).
  function automatic sig_table_t build_sig_table();
    sig_table_t      tbl;
    longint unsigned r;
    longint unsigned b;
    longint unsigned m;
    longint unsigned den;
    longint unsigned num;
    longint unsigned rem;
    longint unsigned s;
    longint          x;
    for (int i = 0; i < SIGMOID_DEPTH; i++) begin
      x = longint'((i * 4096) / SIGMOID_DEPTH) - 64'sd2048;
      m = (x < 0) ? longint'(-x) : longint'(x);
      r = 64'd4294967296;
      b = 64'd4278222805;
      for (int k = 0; k < 13; k++) begin
        if (m[0]) begin
          r = (r * b + 64'h8000_0000) >> 32;
        end
        b = (b * b + 64'h8000_0000) >> 32;
        m = m >> 1;
      end
      den = 64'd4294967296 + r;
      // Rounded quotient by restoring long division, one bit per step.
      num = (64'd1 << 44) + (den >> 1);
      s   = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
        rem = (rem << 1) | {63'd0, num[k]};
        if (rem >= den) begin
          rem  = rem - den;
          s[k] = 1'b1;
        end
      end
      if (x < 0) begin
        tbl[i] = ACT_W'(64'd4096 - s);
      end else begin
        tbl[i] = (s > 64'd4095) ? 12'd4095 : ACT_W'(s);
      end
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

  // Round half up, then drop n fraction bits.
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                   input int n);
    logic signed [PROD_W-1:0] half;
    half = '0;
    half[n-1] = 1'b1;
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [W_W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] c;
    if (v > W_MAX_P) begin
      c = W_MAX_P;
    end else if (v < W_MIN_P) begin
      c = W_MIN_P;
    end else begin
      c = v;
    end
    return c[W_W-1:0];
  endfunction

  function automatic logic [ACT_W-1:0] sigmoid(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W+1:0] off;
    logic [SIG_IDX_W-1:0]    idx;
    off = (SUM_W + 2)'(sum) + SIG_LIM;
    if (off < 0) begin
      idx = '0;
    end else if (off >= (SIG_LIM <<< 1)) begin
      idx = '1;
    end else begin
      idx = off[WEIGHT_FRAC_BITS+3 -: SIG_IDX_W];
    end
    return SIG_TABLE[idx];
  endfunction

endpackage

@@ rtl/mlp_backprop_momentum_step_unit.sv @@
// Handles the 2-2-1 network; a new request is taken only in the idle state, after the
// previous one has left the sequencer. The single shared multiplier is used for all
// 25 products of the forward pass, deltas and nine weight updates.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous): weights, steps and the epoch error sum clear to zero,
// the configuration registers return to 0.5, 0.9 and 26, and both channels go idle.
module mlp_backprop_momentum_step_unit
  import mlpbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] in_a, [1] in_b, [2] target_bit, [7:3] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,       // epoch_end
  // out_tdata: [11:0] net_output, [27:12] pattern_error, [47:28] epoch_error,
  //            [48] converged, [55:49] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int J_W  = $clog2(NUM_HIDDEN + 1);
  localparam int I_W  = $clog2(NUM_INPUTS + 1);
  localparam int K_W  = $clog2(NIH);
  localparam int HI_W = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

  // The sequencer walks the network one phase at a time; each multiply takes one
  // phase to issue and the product is consumed from prod_r in a later phase.
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_HSUM = 8'b0000_0010,
    ST_OSUM = 8'b0000_0100,
    ST_ERR  = 8'b0000_1000,
    ST_DHID = 8'b0001_0000,
    ST_UPIH = 8'b0010_0000,
    ST_UPHO = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  localparam logic [2:0] PH_A = 3'd0;
  localparam logic [2:0] PH_B = 3'd1;
  localparam logic [2:0] PH_C = 3'd2;
  localparam logic [2:0] PH_D = 3'd3;
  localparam logic [2:0] PH_E = 3'd4;

  state_t               state_r, state_nxt;
  logic [2:0]           sub_r, sub_nxt;
  logic [J_W-1:0]       j_r, j_nxt;
  logic [I_W-1:0]       i_r, i_nxt;

  logic [11:0]          eta_r, alpha_r;
  logic [15:0]          thr_r;

  logic [NUM_INPUTS:0]  x_r;
  logic                 tgt_r, eoe_r;

  logic signed [W_W-1:0] wih_r [NIH];
  logic signed [W_W-1:0] sih_r [NIH];
  logic signed [W_W-1:0] who_r [NHO];
  logic signed [W_W-1:0] sho_r [NHO];

  logic [ACT_W-1:0]     h_r [NUM_HIDDEN];
  logic [ACT_W-1:0]     o_r;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DO_W-1:0]  do_r;
  logic signed [SDW_W-1:0] sdw_r;
  logic signed [DH_W-1:0]  dh_r [NUM_HIDDEN];
  logic signed [G_W-1:0]   g_r, tt_r;
  logic [EACC_W-1:0]    eacc_r;

  logic [PE_W-1:0]      res_pe_r;
  logic [EACC_W-1:0]    res_esum_r;
  logic                 res_conv_r;

  logic                 out_valid_r;
  logic [ACT_W-1:0]     out_o_r;
  logic [PE_W-1:0]      out_pe_r;
  logic [EACC_W-1:0]    out_esum_r;
  logic                 out_conv_r;

  // Shared multiplier operands and per-state views of the stored values.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [K_W-1:0]       k_w;
  logic [HI_W-1:0]      hi_w;
  logic [J_W-1:0]       woi_w;
  logic [ACT_W-1:0]     h_sel;
  logic signed [W_W-1:0] who_sel, sho_sel, wih_sel, sih_sel;
  logic signed [DH_W-1:0] dh_sel;
  logic                 x_sel;
  logic signed [E_W-1:0] e_w;
  logic signed [SUM_W-1:0] sum_w;
  logic signed [PROD_W-1:0] r9, r12, rf, r24, mom_w, term_w;
  logic signed [W_W-1:0] step_w;
  logic [EACC_W:0]      esum_wide;
  logic [EACC_W-1:0]    esum_w;
  logic                 out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_conv_r, out_esum_r, out_pe_r, out_o_r};
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    k_w   = K_W'(32'(i_r) * NUM_HIDDEN + 32'(j_r));
    hi_w  = (state_r == ST_DHID || state_r == ST_HSUM || state_r == ST_UPIH)
            ? j_r[HI_W-1:0] : HI_W'(j_r - J_W'(1));
    woi_w = (state_r == ST_DHID) ? J_W'(j_r + J_W'(1)) : j_r;
    h_sel   = h_r[hi_w];
    dh_sel  = dh_r[hi_w];
    who_sel = who_r[woi_w];
    sho_sel = sho_r[j_r];
    wih_sel = wih_r[k_w];
    sih_sel = sih_r[k_w];
    x_sel   = x_r[i_r];
    e_w = (tgt_r ? E_W'(4096) : E_W'(0)) - $signed({2'b00, o_r});

    r9  = rnd(prod_r, 9);
    r12 = rnd(prod_r, 12);
    rf  = rnd(prod_r, WEIGHT_FRAC_BITS);
    r24 = rnd(prod_r, 24);

    // Hidden sums add weights directly; the output sum adds rounded products.
    if (state_r == ST_HSUM) begin
      sum_w = ((i_r == '0) ? SUM_W'(0) : acc_r) + (x_sel ? SUM_W'(wih_sel) : SUM_W'(0));
    end else begin
      sum_w = acc_r + SUM_W'(r12);
    end

    // New step: eta term plus momentum on the old step, saturated.
    mom_w = r12;
    if (state_r == ST_UPIH) begin
      term_w = x_sel ? rnd(PROD_W'(g_r), 24 - WEIGHT_FRAC_BITS) : '0;
    end else begin
      term_w = rnd(PROD_W'(tt_r), 24 - WEIGHT_FRAC_BITS);
    end
    step_w = sat_w(term_w + mom_w);

    esum_wide = {1'b0, eacc_r} + (EACC_W + 1)'(r9[PE_W-1:0]);
    esum_w    = esum_wide[EACC_W] ? '1 : esum_wide[EACC_W-1:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_OSUM: begin
        mul_a = MUL_A_W'(who_sel);
        mul_b = MUL_B_W'(h_sel);
      end
      ST_ERR: begin
        priority case (sub_r)
          PH_A: begin
            mul_a = MUL_A_W'(e_w);
            mul_b = MUL_B_W'(e_w);
          end
          PH_B: begin
            mul_a = MUL_A_W'(o_r);
            mul_b = MUL_B_W'(13'd4096 - 13'(o_r));
          end
          default: begin
            mul_a = MUL_A_W'(prod_r[22:0]);
            mul_b = MUL_B_W'(e_w);
          end
        endcase
      end
      ST_DHID: begin
        priority case (sub_r)
          PH_A: begin
            mul_a = MUL_A_W'(who_sel);
            mul_b = MUL_B_W'(do_r);
          end
          PH_B: begin
            mul_a = MUL_A_W'(h_sel);
            mul_b = MUL_B_W'(13'd4096 - 13'(h_sel));
          end
          default: begin
            mul_a = MUL_A_W'(sdw_r);
            mul_b = MUL_B_W'(prod_r[22:0]);
          end
        endcase
      end
      ST_UPIH: begin
        if (sub_r == PH_A) begin
          mul_a = MUL_A_W'(dh_sel);
          mul_b = MUL_B_W'(eta_r);
        end else begin
          mul_a = MUL_A_W'(sih_sel);
          mul_b = MUL_B_W'(alpha_r);
        end
      end
      ST_UPHO: begin
        priority case (sub_r)
          PH_A: begin
            mul_a = MUL_A_W'(do_r);
            mul_b = MUL_B_W'(eta_r);
          end
          PH_D: begin
            mul_a = MUL_A_W'(g_r);
            mul_b = MUL_B_W'(h_sel);
          end
          default: begin
            mul_a = MUL_A_W'(sho_sel);
            mul_b = MUL_B_W'(alpha_r);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_HSUM;
          sub_nxt   = PH_A;
          j_nxt     = '0;
          i_nxt     = '0;
        end
      end
      ST_HSUM: begin
        if (i_r == I_W'(NUM_INPUTS)) begin
          i_nxt = '0;
          if (j_r == J_W'(NUM_HIDDEN - 1)) begin
            state_nxt = ST_OSUM;
            j_nxt     = '0;
          end else begin
            j_nxt = j_r + J_W'(1);
          end
        end else begin
          i_nxt = i_r + I_W'(1);
        end
      end
      ST_OSUM: begin
        if (j_r == '0) begin
          j_nxt = J_W'(1);
        end else if (sub_r == PH_A) begin
          sub_nxt = PH_B;
        end else begin
          sub_nxt = PH_A;
          if (j_r == J_W'(NUM_HIDDEN)) begin
            state_nxt = ST_ERR;
            j_nxt     = '0;
          end else begin
            j_nxt = j_r + J_W'(1);
          end
        end
      end
      ST_ERR: begin
        if (sub_r == PH_D) begin
          state_nxt = ST_DHID;
          sub_nxt   = PH_A;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_DHID: begin
        if (sub_r == PH_D) begin
          sub_nxt = PH_A;
          if (j_r == J_W'(NUM_HIDDEN - 1)) begin
            state_nxt = ST_UPIH;
            j_nxt     = '0;
            i_nxt     = '0;
          end else begin
            j_nxt = j_r + J_W'(1);
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_UPIH: begin
        priority case (sub_r)
          PH_A:    sub_nxt = PH_B;
          PH_B:    sub_nxt = PH_C;
          PH_C: begin
            if (i_r == I_W'(NUM_INPUTS)) begin
              i_nxt   = '0;
              sub_nxt = PH_A;
              if (j_r == J_W'(NUM_HIDDEN - 1)) begin
                state_nxt = ST_UPHO;
                j_nxt     = '0;
              end else begin
                j_nxt = j_r + J_W'(1);
              end
            end else begin
              i_nxt   = i_r + I_W'(1);
              sub_nxt = PH_D;
            end
          end
          default: sub_nxt = PH_C;
        endcase
      end
      ST_UPHO: begin
        priority case (sub_r)
          PH_A:    sub_nxt = PH_B;
          PH_B:    sub_nxt = PH_C;
          PH_C: begin
            if (j_r == J_W'(NUM_HIDDEN)) begin
              state_nxt = ST_OUT;
              sub_nxt   = PH_A;
              j_nxt     = '0;
            end else begin
              j_nxt   = j_r + J_W'(1);
              sub_nxt = PH_D;
            end
          end
          PH_D:    sub_nxt = PH_E;
          default: sub_nxt = PH_C;
        endcase
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sub_r       <= PH_A;
      j_r         <= '0;
      i_r         <= '0;
      eta_r       <= LEARN_RATE_RST;
      alpha_r     <= MOMENTUM_RST;
      thr_r       <= STOP_THR_RST;
      eacc_r      <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < NIH; n++) begin
        wih_r[n] <= '0;
        sih_r[n] <= '0;
      end
      for (int n = 0; n < NHO; n++) begin
        who_r[n] <= '0;
        sho_r[n] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;

      if (cfg_valid) begin
        priority case (cfg_index)
          REG_LEARN_RATE:     eta_r   <= cfg_data[11:0];
          REG_MOMENTUM:       alpha_r <= cfg_data[11:0];
          REG_STOP_THRESHOLD: thr_r   <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == ST_ERR && sub_r == PH_B) begin
        eacc_r <= eoe_r ? '0 : esum_w;
      end

      // Input-hidden update: step and weight saturate to 18 bits.
      if (state_r == ST_UPIH && sub_r == PH_C) begin
        sih_r[k_w] <= step_w;
        wih_r[k_w] <= sat_w(PROD_W'(wih_sel) + PROD_W'(step_w));
      end

      if (state_r == ST_UPHO && sub_r == PH_C) begin
        sho_r[j_r] <= step_w;
        who_r[j_r] <= sat_w(PROD_W'(who_r[j_r]) + PROD_W'(step_w));
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (state_r == ST_IDLE && in_tvalid) begin
      for (int n = 0; n <= NUM_INPUTS; n++) begin
        x_r[n] <= (n == 0) || ((n == 1) && in_tdata[0]) || ((n == 2) && in_tdata[1]);
      end
      tgt_r <= in_tdata[2];
      eoe_r <= in_tlast;
    end

    unique case (state_r)
      ST_HSUM: begin
        acc_r <= sum_w;
        if (i_r == I_W'(NUM_INPUTS)) begin
          h_r[hi_w] <= sigmoid(sum_w);
        end
      end
      ST_OSUM: begin
        if (j_r == '0) begin
          acc_r <= SUM_W'(who_sel);
        end else if (sub_r == PH_B) begin
          acc_r <= sum_w;
          if (j_r == J_W'(NUM_HIDDEN)) begin
            o_r <= sigmoid(sum_w);
          end
        end
      end
      ST_ERR: begin
        if (sub_r == PH_B) begin
          res_pe_r   <= r9[PE_W-1:0];
          res_esum_r <= esum_w;
          res_conv_r <= eoe_r && (esum_w < EACC_W'(thr_r));
        end
        if (sub_r == PH_D) begin
          do_r <= r12[DO_W-1:0];
        end
      end
      ST_DHID: begin
        if (sub_r == PH_B) begin
          sdw_r <= rf[SDW_W-1:0];
        end
        if (sub_r == PH_D) begin
          dh_r[hi_w] <= r24[DH_W-1:0];
        end
      end
      ST_UPIH: begin
        if (sub_r == PH_B) begin
          g_r <= r12[G_W-1:0];
        end
      end
      ST_UPHO: begin
        if (sub_r == PH_B) begin
          g_r  <= r12[G_W-1:0];
          tt_r <= r12[G_W-1:0];
        end
        if (sub_r == PH_E) begin
          tt_r <= r12[G_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_o_r    <= o_r;
          out_pe_r   <= res_pe_r;
          out_esum_r <= res_esum_r;
          out_conv_r <= res_conv_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_HSUM)
    else $error("accepted request did not start the hidden sums");

  a_conv_below_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_conv_r |-> out_esum_r < EACC_W'(thr_r))
    else $error("converged flag raised with epoch error above threshold");

  a_epoch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ERR && sub_r == PH_B && eoe_r |=> eacc_r == '0)
    else $error("epoch error sum not cleared after epoch end");

  a_pe_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pe_r <= 16'd32768)
    else $error("pattern error out of range");
`endif

endmodule
